### sv/ndim_index_iterator_assert.svh
`ifndef NDIM_INDEX_ITERATOR_ASSERT_SVH
`define NDIM_INDEX_ITERATOR_ASSERT_SVH

// Check a same-cycle implication outside reset.
`define NDI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define NDI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ndi_pkg.sv
package ndi_pkg;

    localparam int NDIM             = 4;
    localparam int IDX_W            = $clog2(NDIM);
    localparam int DIGIT_W          = 18;
    localparam int RAW_W            = 16;
    localparam int POS_W            = 64;
    localparam int OP_W             = 2;
    localparam int NDIMS_W          = 3;
    localparam int CFG_IDX_W        = 3;
    localparam int DEF_EXTENT_WIDTH = 16;

    // Configuration register indexes; extent i sits at CFG_EXTENT_0 + i.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_0 = 3'd1;

    typedef enum logic [OP_W-1:0] {
        OP_INC      = 2'd0,
        OP_LOAD_LIN = 2'd1,
        OP_LOAD_RAW = 2'd2,
        OP_NOP      = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CARRY,
        ST_INC_CHK,
        ST_LIN,
        ST_LIN_WAIT,
        ST_NRM_SCAN,
        ST_NRM,
        ST_NRM_WAIT,
        ST_POS_RUN,
        ST_POS_WAIT,
        ST_DONE
    } seq_state_t;

    typedef enum logic {
        UOP_MUL,
        UOP_DIV
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
        logic     short_div;
    } unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_rsp_t;

endpackage

### sv/ndim_index_iterator.sv
// Mixed-radix index counter over four row-major dimensions (dimension 0 slowest).
// Input channel s_*: one word carries an op (increment, load linear position,
// load raw indices and normalize, or no-op), the linear position and four raw
// indices. Result channel m_*: one word per input word with the linear
// position, the four current indices and an overflow flag.
// Configuration: write num_dims at index 0 and extent i at index 1 + i through
// cfg_we / cfg_index / cfg_wdata while the block is idle; unused leading
// dimensions and zero extents count as extent one.
// Timing: one word at a time; s_ready is low while a word is in work.
// Increment and normalize rebuild the position in the shared shift-add unit
// with one Horner multiply-add per dimension 1 to 3, after the carry ripple.
// Load linear runs one 64-step restoring divide per dimension 1 to 3 whose
// extent is above one. Normalize runs one short divide per carried
// dimension before the rebuild.
// The result sits in an output register, so a stalled receiver does not hold
// off the next word until that word is finished too.
// Reset: indices and position clear, num_dims 1, all extents 1, no result.
module ndim_index_iterator #(
    parameter int EXTENT_WIDTH = ndi_pkg::DEF_EXTENT_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [ndi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [EXTENT_WIDTH-1:0]         cfg_wdata,
    // input words
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ndi_pkg::OP_W-1:0]        s_op,
    input  logic [ndi_pkg::POS_W-1:0]       s_linear_in,
    input  logic [ndi_pkg::RAW_W-1:0]       s_raw_idx_0,
    input  logic [ndi_pkg::RAW_W-1:0]       s_raw_idx_1,
    input  logic [ndi_pkg::RAW_W-1:0]       s_raw_idx_2,
    input  logic [ndi_pkg::RAW_W-1:0]       s_raw_idx_3,
    // result words
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ndi_pkg::POS_W-1:0]       m_position,
    output logic [ndi_pkg::DIGIT_W-1:0]     m_cur_idx_0,
    output logic [ndi_pkg::DIGIT_W-1:0]     m_cur_idx_1,
    output logic [ndi_pkg::DIGIT_W-1:0]     m_cur_idx_2,
    output logic [ndi_pkg::DIGIT_W-1:0]     m_cur_idx_3,
    output logic                            m_overflow
);

    localparam int NDIM    = ndi_pkg::NDIM;
    localparam int NDIMS_W = ndi_pkg::NDIMS_W;
    localparam int EW      = EXTENT_WIDTH;

    // Configuration registers.
    logic [NDIMS_W-1:0] num_dims_reg;
    logic [EW-1:0]      extent_reg [NDIM];

    // Effective extents after clamping num_dims and zero extents.
    logic [NDIMS_W-1:0] act_dims;
    logic [EW-1:0]      eff_ext [NDIM];

    logic [ndi_pkg::RAW_W-1:0]   raw_arr [NDIM];
    logic [ndi_pkg::DIGIT_W-1:0] idx_arr [NDIM];

    ndi_pkg::unit_req_t          unit_req;
    ndi_pkg::unit_rsp_t          unit_rsp;
    logic [ndi_pkg::POS_W-1:0]   unit_a;
    logic [EW-1:0]               unit_b;
    logic [ndi_pkg::DIGIT_W-1:0] unit_c;
    logic [ndi_pkg::POS_W-1:0]   unit_result;
    logic [EW-1:0]               unit_remainder;

    // Take register writes; indexes past the last extent are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_dims_reg <= NDIMS_W'(1);
            for (int d = 0; d < NDIM; d++) begin
                extent_reg[d] <= EW'(1);
            end
        end else if (cfg_we) begin
            if (cfg_index == ndi_pkg::CFG_NUM_DIMS) begin
                num_dims_reg <= cfg_wdata[NDIMS_W-1:0];
            end
            for (int d = 0; d < NDIM; d++) begin
                if (cfg_index == ndi_pkg::CFG_EXTENT_0 + ndi_pkg::CFG_IDX_W'(d)) begin
                    extent_reg[d] <= cfg_wdata;
                end
            end
        end
    end

    // Clamp num_dims to 1..NDIM; leading unused dimensions and zero extents
    // act as extent one.
    always_comb begin
        act_dims = num_dims_reg;
        if (num_dims_reg == '0) begin
            act_dims = NDIMS_W'(1);
        end else if (num_dims_reg > NDIMS_W'(NDIM)) begin
            act_dims = NDIMS_W'(NDIM);
        end
        for (int d = 0; d < NDIM; d++) begin
            if ((NDIMS_W'(d) < NDIMS_W'(NDIM) - act_dims) || (extent_reg[d] == '0)) begin
                eff_ext[d] = EW'(1);
            end else begin
                eff_ext[d] = extent_reg[d];
            end
        end
    end

    assign raw_arr[0] = s_raw_idx_0;
    assign raw_arr[1] = s_raw_idx_1;
    assign raw_arr[2] = s_raw_idx_2;
    assign raw_arr[3] = s_raw_idx_3;

    assign m_cur_idx_0 = idx_arr[0];
    assign m_cur_idx_1 = idx_arr[1];
    assign m_cur_idx_2 = idx_arr[2];
    assign m_cur_idx_3 = idx_arr[3];

    // Sequencer: holds the indices and position, steps the shared unit.
    ndi_seq #(
        .EXTENT_WIDTH(EW)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (ndi_pkg::op_t'(s_op)),
        .s_linear_in    (s_linear_in),
        .s_raw_idx      (raw_arr),
        .eff_ext        (eff_ext),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_position     (m_position),
        .m_cur_idx      (idx_arr),
        .m_overflow     (m_overflow),
        .unit_req       (unit_req),
        .unit_rsp       (unit_rsp),
        .unit_a         (unit_a),
        .unit_b         (unit_b),
        .unit_c         (unit_c),
        .unit_result    (unit_result),
        .unit_remainder (unit_remainder)
    );

    // Shared bit-serial multiply / divide unit.
    ndi_unit #(
        .EXTENT_WIDTH(EW)
    ) u_unit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (unit_req),
        .a         (unit_a),
        .b         (unit_b),
        .c         (unit_c),
        .rsp       (unit_rsp),
        .result    (unit_result),
        .remainder (unit_remainder)
    );

endmodule

### sv/ndi_unit.sv
`include "ndim_index_iterator_assert.svh"

module ndi_unit #(
    parameter int EXTENT_WIDTH = ndi_pkg::DEF_EXTENT_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ndi_pkg::unit_req_t               req,
    input  logic [ndi_pkg::POS_W-1:0]        a,
    input  logic [EXTENT_WIDTH-1:0]          b,
    input  logic [ndi_pkg::DIGIT_W-1:0]      c,
    output ndi_pkg::unit_rsp_t               rsp,
    output logic [ndi_pkg::POS_W-1:0]        result,
    output logic [EXTENT_WIDTH-1:0]          remainder
);

    localparam int POS_W   = ndi_pkg::POS_W;
    localparam int DIGIT_W = ndi_pkg::DIGIT_W;
    localparam int EW      = EXTENT_WIDTH;
    localparam int CNT_W   = $clog2(POS_W + 1);
    localparam int PAD_W   = POS_W - DIGIT_W;

    logic [POS_W-1:0]   acc_reg, acc_next;
    logic [POS_W-1:0]   mcand_reg, mcand_next;
    logic [EW-1:0]      oper_reg, oper_next;
    logic [EW-1:0]      rem_reg, rem_next;
    logic [DIGIT_W-1:0] addend_reg, addend_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    ndi_pkg::unit_op_t  op_reg, op_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [POS_W-1:0]   add_x, add_y;
    logic               add_cin;
    logic [POS_W:0]     add_sum;

    // One adder serves shift-add multiply, the final addend and trial subtract.
    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{POS_W{1'b0}}, add_cin};

    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_cin = 1'b0;
        if (op_reg == ndi_pkg::UOP_DIV) begin
            add_x   = POS_W'({rem_reg, acc_reg[POS_W-1]});
            add_y   = ~POS_W'(oper_reg);
            add_cin = 1'b1;
        end else if (cnt_reg == CNT_W'(1)) begin
            add_x = acc_reg;
            add_y = POS_W'(addend_reg);
        end else begin
            add_x = {acc_reg[POS_W-2:0], 1'b0};
            add_y = oper_reg[EW-1] ? mcand_reg : '0;
        end
    end

    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        oper_next   = oper_reg;
        rem_next    = rem_reg;
        addend_next = addend_reg;
        cnt_next    = cnt_reg;
        op_next     = op_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (req.start) begin
            busy_next   = 1'b1;
            op_next     = req.op;
            mcand_next  = a;
            oper_next   = b;
            addend_next = c;
            rem_next    = '0;
            if (req.op == ndi_pkg::UOP_DIV) begin
                if (req.short_div) begin
                    acc_next = {a[DIGIT_W-1:0], {PAD_W{1'b0}}};
                    cnt_next = CNT_W'(DIGIT_W);
                end else begin
                    acc_next = a;
                    cnt_next = CNT_W'(POS_W);
                end
            end else begin
                acc_next = '0;
                cnt_next = CNT_W'(EW + 1);
            end
        end else if (busy_reg) begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            if (op_reg == ndi_pkg::UOP_DIV) begin
                rem_next = add_sum[POS_W] ? add_sum[EW-1:0] : add_x[EW-1:0];
                acc_next = {acc_reg[POS_W-2:0], add_sum[POS_W]};
            end else begin
                acc_next  = add_sum[POS_W-1:0];
                oper_next = {oper_reg[EW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= ndi_pkg::UOP_MUL;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        oper_reg   <= oper_next;
        rem_reg    <= rem_next;
        addend_reg <= addend_next;
    end

    assign rsp       = '{busy: busy_reg, done: done_reg};
    assign result    = acc_reg;
    assign remainder = rem_reg;

    `NDI_ASSERT_NOW(a_busy_count, busy_reg, cnt_reg != '0, "unit busy with zero step count")
    `NDI_ASSERT_NEXT(a_done_after_last, busy_reg && cnt_reg == CNT_W'(1), done_reg && !busy_reg, "unit did not finish after last step")

endmodule

### sv/ndi_seq.sv
`include "ndim_index_iterator_assert.svh"

module ndi_seq #(
    parameter int EXTENT_WIDTH = ndi_pkg::DEF_EXTENT_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ndi_pkg::op_t                  s_op,
    input  logic [ndi_pkg::POS_W-1:0]     s_linear_in,
    input  logic [ndi_pkg::RAW_W-1:0]     s_raw_idx [ndi_pkg::NDIM],
    input  logic [EXTENT_WIDTH-1:0]       eff_ext [ndi_pkg::NDIM],
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ndi_pkg::POS_W-1:0]     m_position,
    output logic [ndi_pkg::DIGIT_W-1:0]   m_cur_idx [ndi_pkg::NDIM],
    output logic                          m_overflow,
    output ndi_pkg::unit_req_t            unit_req,
    input  ndi_pkg::unit_rsp_t            unit_rsp,
    output logic [ndi_pkg::POS_W-1:0]     unit_a,
    output logic [EXTENT_WIDTH-1:0]       unit_b,
    output logic [ndi_pkg::DIGIT_W-1:0]   unit_c,
    input  logic [ndi_pkg::POS_W-1:0]     unit_result,
    input  logic [EXTENT_WIDTH-1:0]       unit_remainder
);

    localparam int NDIM    = ndi_pkg::NDIM;
    localparam int IDX_W   = ndi_pkg::IDX_W;
    localparam int POS_W   = ndi_pkg::POS_W;
    localparam int DIGIT_W = ndi_pkg::DIGIT_W;
    localparam int EW      = EXTENT_WIDTH;
    localparam int CMP_W   = (EW > DIGIT_W) ? EW : DIGIT_W;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(NDIM - 1);

    ndi_pkg::seq_state_t state_reg, state_next;
    ndi_pkg::op_t        op_reg, op_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic [DIGIT_W-1:0]  digit_reg [NDIM];
    logic [DIGIT_W-1:0]  digit_next [NDIM];
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    work_reg, work_next;
    logic [DIGIT_W-1:0]  carry_reg, carry_next;
    logic                m_valid_reg, m_valid_next;
    logic [POS_W-1:0]    m_pos_reg, m_pos_next;
    logic [DIGIT_W-1:0]  m_idx_reg [NDIM];
    logic [DIGIT_W-1:0]  m_idx_next [NDIM];
    logic                m_ovf_reg, m_ovf_next;

    logic [DIGIT_W-1:0]  cur_digit;
    logic [EW-1:0]       cur_ext;
    logic                cur_ge;
    logic                ovf_now;

    assign cur_digit = digit_reg[cur_reg];
    assign cur_ext   = eff_ext[cur_reg];
    assign cur_ge    = CMP_W'(cur_digit) >= CMP_W'(cur_ext);
    assign ovf_now   = CMP_W'(digit_reg[0]) > CMP_W'(eff_ext[0]);

    assign unit_b = cur_ext;
    assign unit_c = cur_digit;

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        cur_next     = cur_reg;
        digit_next   = digit_reg;
        pos_next     = pos_reg;
        work_next    = work_reg;
        carry_next   = carry_reg;
        m_pos_next   = m_pos_reg;
        m_idx_next   = m_idx_reg;
        m_ovf_next   = m_ovf_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        unit_req     = '{start: 1'b0, op: ndi_pkg::UOP_MUL, short_div: 1'b0};
        unit_a       = pos_reg;

        case (state_reg)
            ndi_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next  = s_op;
                    cur_next = LAST;
                    case (s_op)
                        ndi_pkg::OP_INC: begin
                            carry_next = DIGIT_W'(1);
                            state_next = ndi_pkg::ST_CARRY;
                        end
                        ndi_pkg::OP_LOAD_LIN: begin
                            work_next  = s_linear_in;
                            pos_next   = s_linear_in;
                            state_next = ndi_pkg::ST_LIN;
                        end
                        ndi_pkg::OP_LOAD_RAW: begin
                            for (int d = 0; d < NDIM; d++) begin
                                digit_next[d] = DIGIT_W'(s_raw_idx[d]);
                            end
                            state_next = ndi_pkg::ST_NRM_SCAN;
                        end
                        default: begin
                            state_next = ndi_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            // Add the pending carry into the current digit.
            ndi_pkg::ST_CARRY: begin
                digit_next[cur_reg] = cur_digit + carry_reg;
                state_next = (op_reg == ndi_pkg::OP_INC) ? ndi_pkg::ST_INC_CHK
                                                         : ndi_pkg::ST_NRM;
            end

            ndi_pkg::ST_INC_CHK: begin
                if (cur_ge && cur_reg != '0) begin
                    digit_next[cur_reg] = '0;
                    cur_next   = cur_reg - IDX_W'(1);
                    state_next = ndi_pkg::ST_CARRY;
                end else begin
                    pos_next   = POS_W'(digit_reg[0]);
                    cur_next   = IDX_W'(1);
                    state_next = ndi_pkg::ST_POS_RUN;
                end
            end

            ndi_pkg::ST_LIN: begin
                unit_a = work_reg;
                if (cur_reg == '0) begin
                    digit_next[0] = (|work_reg[POS_W-1:DIGIT_W]) ? '1 : work_reg[DIGIT_W-1:0];
                    state_next = ndi_pkg::ST_DONE;
                end else if (cur_ext == EW'(1)) begin
                    digit_next[cur_reg] = '0;
                    cur_next = cur_reg - IDX_W'(1);
                end else begin
                    unit_req   = '{start: 1'b1, op: ndi_pkg::UOP_DIV, short_div: 1'b0};
                    state_next = ndi_pkg::ST_LIN_WAIT;
                end
            end

            ndi_pkg::ST_LIN_WAIT: begin
                if (unit_rsp.done) begin
                    digit_next[cur_reg] = DIGIT_W'(unit_remainder);
                    work_next  = unit_result;
                    cur_next   = cur_reg - IDX_W'(1);
                    state_next = ndi_pkg::ST_LIN;
                end
            end

            // Find the highest digit that is out of range.
            ndi_pkg::ST_NRM_SCAN: begin
                if (cur_ge) begin
                    state_next = ndi_pkg::ST_NRM;
                end else if (cur_reg == '0) begin
                    pos_next   = POS_W'(digit_reg[0]);
                    cur_next   = IDX_W'(1);
                    state_next = ndi_pkg::ST_POS_RUN;
                end else begin
                    cur_next = cur_reg - IDX_W'(1);
                end
            end

            ndi_pkg::ST_NRM: begin
                unit_a = POS_W'(cur_digit);
                if (cur_ge && cur_reg != '0) begin
                    unit_req   = '{start: 1'b1, op: ndi_pkg::UOP_DIV, short_div: 1'b1};
                    state_next = ndi_pkg::ST_NRM_WAIT;
                end else begin
                    pos_next   = POS_W'(digit_reg[0]);
                    cur_next   = IDX_W'(1);
                    state_next = ndi_pkg::ST_POS_RUN;
                end
            end

            ndi_pkg::ST_NRM_WAIT: begin
                if (unit_rsp.done) begin
                    digit_next[cur_reg] = DIGIT_W'(unit_remainder);
                    carry_next = unit_result[DIGIT_W-1:0];
                    cur_next   = cur_reg - IDX_W'(1);
                    state_next = ndi_pkg::ST_CARRY;
                end
            end

            // Horner step: position = position * extent + digit.
            ndi_pkg::ST_POS_RUN: begin
                unit_req   = '{start: 1'b1, op: ndi_pkg::UOP_MUL, short_div: 1'b0};
                state_next = ndi_pkg::ST_POS_WAIT;
            end

            ndi_pkg::ST_POS_WAIT: begin
                if (unit_rsp.done) begin
                    pos_next = unit_result;
                    if (cur_reg == LAST) begin
                        state_next = ndi_pkg::ST_DONE;
                    end else begin
                        cur_next   = cur_reg + IDX_W'(1);
                        state_next = ndi_pkg::ST_POS_RUN;
                    end
                end
            end

            ndi_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_pos_next   = pos_reg;
                    m_idx_next   = digit_reg;
                    m_ovf_next   = ovf_now;
                    state_next   = ndi_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = ndi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ndi_pkg::ST_IDLE;
            op_reg      <= ndi_pkg::OP_NOP;
            cur_reg     <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int d = 0; d < NDIM; d++) begin
                digit_reg[d] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            cur_reg     <= cur_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
            digit_reg   <= digit_next;
        end
        work_reg  <= work_next;
        carry_reg <= carry_next;
        m_pos_reg <= m_pos_next;
        m_idx_reg <= m_idx_next;
        m_ovf_reg <= m_ovf_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_position = m_pos_reg;
    assign m_cur_idx  = m_idx_reg;
    assign m_overflow = m_ovf_reg;

    `NDI_ASSERT_NOW(a_start_unit_free, unit_req.start, !unit_rsp.busy, "unit started while busy")
    `NDI_ASSERT_NOW(a_carry_has_target, state_reg == ndi_pkg::ST_NRM_WAIT, cur_reg != '0, "carry out of dimension 0")
    `NDI_ASSERT_NEXT(a_accept_leaves_idle, s_valid && s_ready, state_reg != ndi_pkg::ST_IDLE, "accepted word not started")

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import ndi_pkg::*;

    // One result word as the predictor sees it; idx[d] is dimension d.
    typedef struct packed {
        logic [POS_W-1:0]             position;
        logic [NDIM-1:0][DIGIT_W-1:0] idx;
        logic                         overflow;
    } index_word_t;

    typedef logic [NDIM-1:0][RAW_W-1:0] raw_set_t;

    // One line of the directed table: either a register write or an input word.
    // Rows marked typed carry their result as written here.
    typedef struct {
        bit                          is_write;
        logic [CFG_IDX_W-1:0]        reg_idx;
        logic [DEF_EXTENT_WIDTH-1:0] reg_val;
        op_t                         op;
        logic [POS_W-1:0]            lin;
        raw_set_t                    raw;
        bit                          typed;
        index_word_t                 want;
    } plan_row_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                        aclk;
    logic                        aresetn = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [DEF_EXTENT_WIDTH-1:0] cfg_wdata = '0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [OP_W-1:0]             s_op = '0;
    logic [POS_W-1:0]            s_linear_in = '0;
    logic [RAW_W-1:0]            s_raw_idx_0 = '0;
    logic [RAW_W-1:0]            s_raw_idx_1 = '0;
    logic [RAW_W-1:0]            s_raw_idx_2 = '0;
    logic [RAW_W-1:0]            s_raw_idx_3 = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [POS_W-1:0]            m_position;
    logic [DIGIT_W-1:0]          m_cur_idx_0;
    logic [DIGIT_W-1:0]          m_cur_idx_1;
    logic [DIGIT_W-1:0]          m_cur_idx_2;
    logic [DIGIT_W-1:0]          m_cur_idx_3;
    logic                        m_overflow;

    ndim_index_iterator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_linear_in (s_linear_in),
        .s_raw_idx_0 (s_raw_idx_0),
        .s_raw_idx_1 (s_raw_idx_1),
        .s_raw_idx_2 (s_raw_idx_2),
        .s_raw_idx_3 (s_raw_idx_3),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_position  (m_position),
        .m_cur_idx_0 (m_cur_idx_0),
        .m_cur_idx_1 (m_cur_idx_1),
        .m_cur_idx_2 (m_cur_idx_2),
        .m_cur_idx_3 (m_cur_idx_3),
        .m_overflow  (m_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor: private copy of the registers, the digits and the position.
    // Initial values match the state right after reset.
    // ------------------------------------------------------------------
    logic [NDIMS_W-1:0]          dims_cfg = 3'd1;
    logic [DEF_EXTENT_WIDTH-1:0] extent_cfg [NDIM] = '{default: 1};
    logic [DIGIT_W-1:0]          digit_q [NDIM] = '{default: 0};
    logic [POS_W-1:0]            pos_q = '0;

    index_word_t expected_words[$];
    int          mismatch_count = 0;
    bit          src_burst = 1'b0;
    bit          snk_burst = 1'b0;

    // Clamp num_dims into 1..NDIM.
    function automatic int unsigned used_dims();
        if (dims_cfg < 1) return 1;
        if (dims_cfg > NDIM) return NDIM;
        return dims_cfg;
    endfunction

    // Effective size of dimension d: unused leading dims and zero extents count as one.
    function automatic logic [POS_W-1:0] dim_size(int d);
        if (d < NDIM - int'(used_dims())) return 1;
        if (extent_cfg[d] == 0) return 1;
        return POS_W'(extent_cfg[d]);
    endfunction

    // Rebuild the row-major position from the digits; wraps modulo 2^64.
    function automatic logic [POS_W-1:0] row_major_pos();
        logic [POS_W-1:0] acc;
        logic [POS_W-1:0] stride;
        int               d;
        acc    = '0;
        stride = 1;
        for (d = NDIM - 1; d >= 0; d--) begin
            acc    = acc + POS_W'(digit_q[d]) * stride;
            stride = stride * dim_size(d);
        end
        return acc;
    endfunction

    // Bump the fastest digit and ripple toward dimension 0; dimension 0 may
    // run past its extent, digits wrap at 18 bits.
    function automatic void step_increment();
        int cur;
        cur = NDIM - 1;
        digit_q[cur] = digit_q[cur] + 1'b1;
        while (cur > 0 && POS_W'(digit_q[cur]) >= dim_size(cur)) begin
            digit_q[cur] = '0;
            cur--;
            digit_q[cur] = digit_q[cur] + 1'b1;
        end
        pos_q = row_major_pos();
    endfunction

    // Split a position into digits; dimension 0 keeps the saturated quotient.
    function automatic void step_load_linear(logic [POS_W-1:0] lin);
        logic [POS_W-1:0] rest;
        logic [POS_W-1:0] e;
        int               d;
        rest = lin;
        for (d = NDIM - 1; d >= 1; d--) begin
            e          = dim_size(d);
            digit_q[d] = DIGIT_W'(rest % e);
            rest       = rest / e;
        end
        digit_q[0] = (rest > POS_W'({DIGIT_W{1'b1}})) ? '1 : DIGIT_W'(rest);
        pos_q = lin;
    endfunction

    // Load raw digits, then carry from the highest out-of-range dimension
    // toward dimension 0, stopping at the first digit that fits.
    function automatic void step_normalize(raw_set_t raw);
        logic [POS_W-1:0] e;
        logic [POS_W-1:0] v;
        int               d;
        int               cur;
        for (d = 0; d < NDIM; d++)
            digit_q[d] = DIGIT_W'(raw[d]);
        cur = -1;
        for (d = NDIM - 1; d >= 0; d--) begin
            if (POS_W'(digit_q[d]) >= dim_size(d)) begin
                cur = d;
                break;
            end
        end
        while (cur > 0 && POS_W'(digit_q[cur]) >= dim_size(cur)) begin
            e            = dim_size(cur);
            v            = POS_W'(digit_q[cur]);
            digit_q[cur] = DIGIT_W'(v % e);
            cur--;
            digit_q[cur] = DIGIT_W'(POS_W'(digit_q[cur]) + v / e);
        end
        pos_q = row_major_pos();
    endfunction

    // Apply one accepted input word and return the result word it produces.
    function automatic index_word_t advance_index(op_t op, logic [POS_W-1:0] lin,
                                                  raw_set_t raw);
        index_word_t w;
        int          d;
        case (op)
            OP_INC:      step_increment();
            OP_LOAD_LIN: step_load_linear(lin);
            OP_LOAD_RAW: step_normalize(raw);
            default:     ;  // no-op: just report the held state
        endcase
        w.position = pos_q;
        for (d = 0; d < NDIM; d++)
            w.idx[d] = digit_q[d];
        w.overflow = (POS_W'(digit_q[0]) > dim_size(0));
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------
    function automatic raw_set_t raw4(logic [RAW_W-1:0] r0, logic [RAW_W-1:0] r1,
                                      logic [RAW_W-1:0] r2, logic [RAW_W-1:0] r3);
        raw_set_t r;
        r[0] = r0;
        r[1] = r1;
        r[2] = r2;
        r[3] = r3;
        return r;
    endfunction

    function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [DEF_EXTENT_WIDTH-1:0] val);
        plan_row_t row;
        row          = '{op: OP_NOP, default: '0};
        row.is_write = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        row.op      = OP_NOP;
        return row;
    endfunction

    function automatic plan_row_t word_row(op_t op, logic [POS_W-1:0] lin, raw_set_t raw);
        plan_row_t row;
        row     = '{op: OP_NOP, default: '0};
        row.op  = op;
        row.lin = lin;
        row.raw = raw;
        return row;
    endfunction

    // Row whose result is known outright: only digit 0 can be nonzero here.
    function automatic plan_row_t known_row(op_t op, logic [POS_W-1:0] lin, raw_set_t raw,
                                            logic [POS_W-1:0] pos, logic [DIGIT_W-1:0] d0,
                                            logic ovf);
        plan_row_t row;
        row               = word_row(op, lin, raw);
        row.typed         = 1'b1;
        row.want.position = pos;
        row.want.idx      = '0;
        row.want.idx[0]   = d0;
        row.want.overflow = ovf;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Random draws
    // ------------------------------------------------------------------
    // Mostly small extents so increments ripple often; hit zero and max too.
    function automatic logic [DEF_EXTENT_WIDTH-1:0] draw_extent();
        case ($urandom_range(0, 9))
            0:             return '0;
            1:             return '1;
            2, 3, 4, 5, 6: return DEF_EXTENT_WIDTH'($urandom_range(1, 6));
            7, 8:          return DEF_EXTENT_WIDTH'($urandom_range(2, 300));
            default:       return DEF_EXTENT_WIDTH'($urandom_range(1, 65535));
        endcase
    endfunction

    // Positions mostly inside the index space, some right at its end, some past it.
    function automatic logic [POS_W-1:0] draw_linear();
        logic [POS_W-1:0] total;
        logic [POS_W-1:0] wide;
        int               d;
        total = 1;
        for (d = 0; d < NDIM; d++)
            total = total * dim_size(d);
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return wide % total;
            4, 5:       return total - 1 - (POS_W'($urandom_range(0, 3)) % total);
            6:          return total * POS_W'($urandom_range(1, 4)) +
                               POS_W'($urandom_range(0, 9));
            7:          return POS_W'($urandom_range(0, 1000));
            default:    return wide;
        endcase
    endfunction

    // Raw digits mostly in range, some a few extents over, some anything.
    function automatic raw_set_t draw_raw();
        raw_set_t         raw;
        logic [POS_W-1:0] e;
        int               d;
        for (d = 0; d < NDIM; d++) begin
            e = dim_size(d);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: raw[d] = RAW_W'($urandom % e);
                6, 7:             raw[d] = RAW_W'($urandom % (3 * e));
                default:          raw[d] = RAW_W'($urandom_range(0, 65535));
            endcase
        end
        return raw;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------
    // Write one register; hold cfg_we high so back-to-back writes never
    // drop and raise it in the same step. send_word lowers it.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DEF_EXTENT_WIDTH-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_NUM_DIMS)
            dims_cfg = val[NDIMS_W-1:0];
        else if (idx >= CFG_EXTENT_0 && idx < CFG_EXTENT_0 + NDIM)
            extent_cfg[idx - CFG_EXTENT_0] = val;
        @(posedge aclk);
    endtask

    // Offer one input word, wait for the handshake, then log its expected result.
    // Valid is left high on return so a zero gap keeps the channel busy.
    task automatic send_word(op_t op, logic [POS_W-1:0] lin, raw_set_t raw, bit typed,
                             index_word_t want);
        int          gap;
        index_word_t got;
        cfg_we <= 1'b0;
        if ($urandom_range(0, 39) == 0)
            src_burst = !src_burst;
        gap = src_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_op        <= op;
        s_linear_in <= lin;
        s_raw_idx_0 <= raw[0];
        s_raw_idx_1 <= raw[1];
        s_raw_idx_2 <= raw[2];
        s_raw_idx_3 <= raw[3];
        do @(posedge aclk); while (s_ready !== 1'b1);
        got = advance_index(op, lin, raw);
        expected_words.push_back(typed ? want : got);
    endtask

    // Drop valid and wait until every outstanding result word has come back.
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, compare each accepted word field by field
    // ------------------------------------------------------------------
    task automatic check_word(index_word_t want);
        logic [DIGIT_W-1:0] seen_idx [NDIM];
        int                 d;
        seen_idx = '{m_cur_idx_0, m_cur_idx_1, m_cur_idx_2, m_cur_idx_3};
        if (m_position !== want.position) begin
            $error("position: expected %h, got %h", want.position, m_position);
            mismatch_count++;
        end
        for (d = 0; d < NDIM; d++) begin
            if (seen_idx[d] !== want.idx[d]) begin
                $error("cur_idx_%0d: expected %h, got %h", d, want.idx[d], seen_idx[d]);
                mismatch_count++;
            end
        end
        if (m_overflow !== want.overflow) begin
            $error("overflow: expected %b, got %b", want.overflow, m_overflow);
            mismatch_count++;
        end
    endtask

    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0)
                snk_burst = !snk_burst;
            stall = snk_burst ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected: position %h", m_position);
                mismatch_count++;
            end else begin
                check_word(expected_words.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        plan_row_t                   plan[$];
        logic [DEF_EXTENT_WIDTH-1:0] ext [NDIM];
        logic [NDIMS_W-1:0]          ndims;
        index_word_t                 none;
        op_t                         op;
        int                          pick;
        int                          d;

        none = '0;

        plan = '{
            // After reset every dimension has extent one.
            known_row(OP_NOP,      '0, '0, 64'd0, 18'd0, 1'b0),
            // Increment ripples all the way into dimension 0: end state.
            known_row(OP_INC,      '0, '0, 64'd1, 18'd1, 1'b0),
            // One past the end state: overflow.
            known_row(OP_INC,      '0, '0, 64'd2, 18'd2, 1'b1),
            // Largest position: digit 0 saturates, position passes through.
            known_row(OP_LOAD_LIN, '1, '0, '1, 18'h3FFFF, 1'b1),
            // Digit 0 wraps at 18 bits; unused fields all ones.
            known_row(OP_INC,      '1, '1, 64'd0, 18'd0, 1'b0),
            // All raw digits full: every carry lands in dimension 0.
            known_row(OP_LOAD_RAW, '0, '1, 64'h3FFFC, 18'h3FFFC, 1'b1),

            reg_row(CFG_NUM_DIMS, 16'd4),
            reg_row(CFG_EXTENT_0,        16'd3),
            reg_row(CFG_EXTENT_0 + 3'd1, 16'd5),
            reg_row(CFG_EXTENT_0 + 3'd2, 16'd7),
            reg_row(CFG_EXTENT_0 + 3'd3, 16'd11),
            known_row(OP_LOAD_LIN, '0, '0, 64'd0, 18'd0, 1'b0),
            word_row(OP_INC,      '0, '0),
            word_row(OP_LOAD_LIN, 64'd1154, '0),          // last in-range position
            word_row(OP_INC,      '0, '0),                // full ripple to end state
            word_row(OP_INC,      '0, '0),                // keep counting past the end
            word_row(OP_LOAD_LIN, 64'd5000, '0),          // quotient past extent 0
            word_row(OP_LOAD_RAW, '0, raw4(16'd2, 16'd9, 16'd3, 16'hFFFF)),
            word_row(OP_LOAD_RAW, '0, raw4(16'd1, 16'd40, 16'd3, 16'd4)),
            word_row(OP_LOAD_RAW, '0, raw4(16'd2, 16'd4, 16'd6, 16'd10)),

            // Zero extent counts as one.
            reg_row(CFG_EXTENT_0 + 3'd3, 16'd0),
            word_row(OP_INC,      '0, '0),
            // num_dims zero counts as one.
            reg_row(CFG_NUM_DIMS, 16'd0),
            word_row(OP_LOAD_LIN, 64'd5, '1),
            word_row(OP_INC,      '0, '0),
            // num_dims above four counts as four; largest extents.
            reg_row(CFG_NUM_DIMS, 16'd7),
            reg_row(CFG_EXTENT_0,        16'hFFFF),
            reg_row(CFG_EXTENT_0 + 3'd1, 16'hFFFF),
            reg_row(CFG_EXTENT_0 + 3'd2, 16'hFFFF),
            reg_row(CFG_EXTENT_0 + 3'd3, 16'hFFFF),
            word_row(OP_LOAD_LIN, '1, '0),
            word_row(OP_INC,      '0, '0),
            word_row(OP_LOAD_RAW, '0, '1),
            word_row(OP_NOP,      '1, '1)
        };

        // Hold reset at the start, then release it for good.
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table; drain before any register write.
        foreach (plan[k]) begin
            if (plan[k].is_write) begin
                drain();
                write_reg(plan[k].reg_idx, plan[k].reg_val);
            end else begin
                send_word(plan[k].op, plan[k].lin, plan[k].raw, plan[k].typed, plan[k].want);
            end
        end

        // Random phases: the first two pin the extremes, the rest draw a setting.
        for (int phase = 0; phase < 10; phase++) begin
            if (phase == 0) begin
                ndims = 3'd4;
                ext   = '{default: 16'hFFFF};
            end else if (phase == 1) begin
                ndims = 3'd1;
                ext   = '{default: 16'd1};
            end else begin
                ndims = ($urandom_range(0, 9) == 0) ? NDIMS_W'($urandom_range(0, 7))
                                                    : NDIMS_W'($urandom_range(1, 4));
                for (d = 0; d < NDIM; d++)
                    ext[d] = draw_extent();
            end
            drain();
            write_reg(CFG_NUM_DIMS, DEF_EXTENT_WIDTH'(ndims));
            for (d = 0; d < NDIM; d++)
                write_reg(CFG_EXTENT_0 + CFG_IDX_W'(d), ext[d]);

            // Lean on increments so carries ripple; loads seed interesting spots.
            for (int n = 0; n < 65; n++) begin
                pick = $urandom_range(0, 19);
                op   = (pick < 9)  ? OP_INC :
                       (pick < 14) ? OP_LOAD_LIN :
                       (pick < 19) ? OP_LOAD_RAW : OP_NOP;
                send_word(op, draw_linear(), draw_raw(), 1'b0, none);
            end
        end

        drain();
        // Give the block time to show any stray word.
        repeat (250) @(posedge aclk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/ndi_pkg.sv
sv/ndi_unit.sv
sv/ndi_seq.sv
sv/ndim_index_iterator.sv
bench/tb_top.sv
